// ===== hw/rtl/tts_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tts_pkg
// Shared types and constants of the timed task scheduler.
// ----------------------------------------------------------------------------
package tts_pkg;

  localparam int NUM_SLOTS = 32;
  localparam int MAX_FIRES = 63;
  localparam int SLOT_W    = $clog2(NUM_SLOTS);
  localparam int FIRE_W    = $clog2(MAX_FIRES + 1);

  localparam logic [31:0] SAT32   = 32'hFFFF_FFFF;
  localparam logic [19:0] TPS_RST = 20'd1000;

  typedef enum logic [1:0] {
    KIND_PERIODIC = 2'd0,
    KIND_ONESHOT  = 2'd1,
    KIND_CANCEL   = 2'd2,
    KIND_CHECK    = 2'd3
  } kind_t;

  typedef enum logic {
    SAT_MUL = 1'b0,
    SAT_ADD = 1'b1
  } sat_op_t;

  typedef struct packed {
    sat_op_t     op;
    logic [31:0] a;
    logic [31:0] b;
  } sat_req_t;

endpackage
`default_nettype wire

// ===== hw/rtl/tts_sat_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tts_sat_unit
// Shared saturating unit: 16x20 multiply or 32-bit add, result registered.
// ----------------------------------------------------------------------------
module tts_sat_unit (
  input  wire logic             clk,
  input  wire tts_pkg::sat_req_t req,
  output logic [31:0]           result
);
  import tts_pkg::*;

  logic [35:0] prod;
  logic [32:0] sum;

  assign prod = {20'b0, req.a[15:0]} * {16'b0, req.b[19:0]};
  assign sum  = {1'b0, req.a} + {1'b0, req.b};

  always_ff @(posedge clk) begin
    case (req.op)
      SAT_MUL: result <= (|prod[35:32]) ? SAT32 : prod[31:0];
      SAT_ADD: result <= sum[32] ? SAT32 : sum[31:0];
      default: result <= SAT32;
    endcase
  end

endmodule
`default_nettype wire

// ===== hw/rtl/timed_task_scheduler_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// timed_task_scheduler_unit
// Table of periodic and one-shot task slots fired in due-time order.
//
// Input channel (in_valid/in_stall): one transaction is a start, cancel or
// check command. in_stall is high while a command is being worked on.
// Output channel (out_valid/out_stall): records from a single output
// register; every command ends with a summary record flagged by last.
// Config channel (cfg_valid/cfg_ready): writes ticks_per_second; always ready.
// A periodic start runs the init multiply, period multiply, due add and due
// write states; one-shot start and cancel use one apply state. A check scans
// all slots through the due-tick memory read port, one slot a cycle, fires the
// earliest due slot, rewrites a periodic slot's due tick, and rescans per fire.
// A stalled output record holds; the sequencer waits when a new record is
// ready while the output register is still full. The next command may be
// accepted while the last summary still waits.
// Reset clears all slots and sets ticks_per_second to 1000.
// ----------------------------------------------------------------------------
module timed_task_scheduler_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [19:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  kind,
  input  wire logic [4:0]  slot,
  input  wire logic [31:0] now,
  input  wire logic [15:0] initial_wait_secs,
  input  wire logic [15:0] period_secs,
  input  wire logic [31:0] run_when,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             record_kind,
  output logic [4:0]       fired_slot,
  output logic             was_late,
  output logic [31:0]      lateness,
  output logic [31:0]      ticks_to_next,
  output logic             table_empty,
  output logic             any_fired,
  output logic             more_pending,
  output logic             last
);
  import tts_pkg::*;

  typedef enum logic [13:0] {
    S_IDLE     = 14'b00000000000001,
    S_MUL_INIT = 14'b00000000000010,
    S_MUL_PER  = 14'b00000000000100,
    S_ADD_DUE  = 14'b00000000001000,
    S_WR_DUE   = 14'b00000000010000,
    S_APPLY    = 14'b00000000100000,
    S_SCAN     = 14'b00000001000000,
    S_SCAN_END = 14'b00000010000000,
    S_DECIDE   = 14'b00000100000000,
    S_FIRE     = 14'b00001000000000,
    S_PREAD    = 14'b00010000000000,
    S_PADD     = 14'b00100000000000,
    S_PWR      = 14'b01000000000000,
    S_SUMMARY  = 14'b10000000000000
  } state_t;

  state_t state, state_next;

  logic [19:0] tps;
  logic [19:0] tps_eff;

  kind_t       kind_q;
  logic [4:0]  slot_q;
  logic [31:0] now_q;
  logic [15:0] init_q;
  logic [15:0] per_q;
  logic [31:0] when_q;
  logic        slot_ok;
  logic [SLOT_W-1:0] slot_idx;

  logic [NUM_SLOTS-1:0] armed;
  logic [NUM_SLOTS-1:0] periodic;

  logic [31:0] due_mem [NUM_SLOTS];
  logic [31:0] per_mem [NUM_SLOTS];
  logic [31:0] due_q;
  logic [31:0] period_q;

  logic [SLOT_W-1:0] scan_idx;
  logic [SLOT_W-1:0] rd_idx;
  logic              rd_pend;
  logic              found;
  logic [SLOT_W-1:0] best_idx;
  logic [31:0]       best_due;
  logic [FIRE_W-1:0] fires;
  logic [31:0]       tmp;

  sat_req_t    req;
  logic [31:0] sat_res;

  logic out_free;
  logic due_lte;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);
  assign out_free  = !out_valid || !out_stall;
  assign tps_eff   = (tps == 20'd0) ? 20'd1 : tps;
  assign slot_ok   = (32'(slot_q) < NUM_SLOTS);
  assign slot_idx  = slot_q[SLOT_W-1:0];
  assign due_lte   = (best_due <= now_q);

  tts_sat_unit u_sat (
    .clk    (clk),
    .req    (req),
    .result (sat_res)
  );

  always_comb begin
    req.op = SAT_MUL;
    req.a  = {16'b0, init_q};
    req.b  = {12'b0, tps_eff};
    case (state)
      S_MUL_PER: begin
        req.a = {16'b0, (per_q == 16'd0) ? 16'd1 : per_q};
      end
      S_ADD_DUE: begin
        req.op = SAT_ADD;
        req.a  = now_q;
        req.b  = tmp;
      end
      S_PADD: begin
        req.op = SAT_ADD;
        req.a  = best_due;
        req.b  = period_q;
      end
      default: ;
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          case (kind_t'(kind))
            KIND_PERIODIC: state_next = S_MUL_INIT;
            KIND_CHECK:    state_next = S_SCAN;
            default:       state_next = S_APPLY;
          endcase
        end
      end
      S_MUL_INIT: state_next = S_MUL_PER;
      S_MUL_PER:  state_next = S_ADD_DUE;
      S_ADD_DUE:  state_next = S_WR_DUE;
      S_WR_DUE:   state_next = S_SUMMARY;
      S_APPLY:    state_next = S_SUMMARY;
      S_SCAN: begin
        if (scan_idx == SLOT_W'(NUM_SLOTS - 1)) state_next = S_SCAN_END;
      end
      S_SCAN_END: state_next = S_DECIDE;
      S_DECIDE: begin
        if (!found || !due_lte || (32'(fires) >= MAX_FIRES)) state_next = S_SUMMARY;
        else state_next = S_FIRE;
      end
      S_FIRE: begin
        if (out_free) state_next = periodic[best_idx] ? S_PREAD : S_SCAN;
      end
      S_PREAD:   state_next = S_PADD;
      S_PADD:    state_next = S_PWR;
      S_PWR:     state_next = S_SCAN;
      S_SUMMARY: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      tps      <= TPS_RST;
      armed    <= '0;
      periodic <= '0;
      rd_pend  <= 1'b0;
      found    <= 1'b0;
      fires    <= '0;
    end else begin
      state   <= state_next;
      rd_pend <= (state == S_SCAN);
      if (cfg_valid && cfg_ready) tps <= cfg_data;
      if (state == S_IDLE && in_valid) fires <= '0;
      if (state == S_WR_DUE && slot_ok) begin
        armed[slot_idx]    <= 1'b1;
        periodic[slot_idx] <= 1'b1;
      end
      if (state == S_APPLY && slot_ok) begin
        armed[slot_idx]    <= (kind_q == KIND_ONESHOT);
        periodic[slot_idx] <= 1'b0;
      end
      if (state == S_SCAN && scan_idx == '0) found <= 1'b0;
      if (rd_pend && armed[rd_idx] && (!found || due_q < best_due)) found <= 1'b1;
      if (state == S_FIRE && out_free) begin
        fires <= fires + 1'b1;
        if (!periodic[best_idx]) armed[best_idx] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      kind_q <= kind_t'(kind);
      slot_q <= slot;
      now_q  <= now;
      init_q <= initial_wait_secs;
      per_q  <= period_secs;
      when_q <= run_when;
    end
    if (state == S_MUL_PER) tmp <= sat_res;
    if (state == S_IDLE) scan_idx <= '0;
    else if (state == S_SCAN) scan_idx <= scan_idx + 1'b1;
    else if (state == S_PWR || state == S_FIRE) scan_idx <= '0;
    rd_idx <= scan_idx;
    if (rd_pend && armed[rd_idx] && (!found || due_q < best_due)) begin
      best_idx <= rd_idx;
      best_due <= due_q;
    end
  end

  always_ff @(posedge clk) begin
    due_q    <= due_mem[scan_idx];
    period_q <= per_mem[best_idx];
    if (state == S_ADD_DUE && slot_ok) per_mem[slot_idx] <= sat_res;
    if (state == S_WR_DUE && slot_ok) due_mem[slot_idx] <= sat_res;
    if (state == S_APPLY && slot_ok && kind_q == KIND_ONESHOT) due_mem[slot_idx] <= when_q;
    if (state == S_PWR) due_mem[best_idx] <= sat_res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == S_FIRE || state == S_SUMMARY) && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FIRE && out_free) begin
      record_kind   <= 1'b0;
      fired_slot    <= 5'(best_idx);
      was_late      <= (now_q > best_due);
      lateness      <= now_q - best_due;
      ticks_to_next <= '0;
      table_empty   <= 1'b0;
      any_fired     <= 1'b0;
      more_pending  <= 1'b0;
      last          <= 1'b0;
    end else if (state == S_SUMMARY && out_free) begin
      record_kind   <= 1'b1;
      fired_slot    <= '0;
      was_late      <= 1'b0;
      lateness      <= '0;
      last          <= 1'b1;
      if (kind_q == KIND_CHECK) begin
        ticks_to_next <= (found && !due_lte) ? (best_due - now_q) : 32'd0;
        table_empty   <= !found;
        any_fired     <= (fires != '0);
        more_pending  <= found && due_lte;
      end else begin
        ticks_to_next <= '0;
        table_empty   <= !(|armed);
        any_fired     <= 1'b0;
        more_pending  <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

// ===== test/timed_task_scheduler_unit_checker.sv =====
// ----------------------------------------------------------------------------
// timed_task_scheduler_unit_checker
// Watches the command, record and rate channels of the scheduler. It keeps its
// own copy of the slot table and the tick rate, predicts the fire and summary
// records of every accepted command, and compares each accepted record with
// the oldest prediction.
// ----------------------------------------------------------------------------
module timed_task_scheduler_unit_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  input  wire logic        cfg_ready,
  input  wire logic [19:0] cfg_data,
  input  wire logic        in_valid,
  input  wire logic        in_stall,
  input  wire logic [1:0]  kind,
  input  wire logic [4:0]  slot,
  input  wire logic [31:0] now,
  input  wire logic [15:0] initial_wait_secs,
  input  wire logic [15:0] period_secs,
  input  wire logic [31:0] run_when,
  input  wire logic        out_valid,
  input  wire logic        out_stall,
  input  wire logic        record_kind,
  input  wire logic [4:0]  fired_slot,
  input  wire logic        was_late,
  input  wire logic [31:0] lateness,
  input  wire logic [31:0] ticks_to_next,
  input  wire logic        table_empty,
  input  wire logic        any_fired,
  input  wire logic        more_pending,
  input  wire logic        last,
  output int               mismatches,
  output int               pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import tts_pkg::*;

  typedef struct packed {
    logic              record_kind;
    logic [SLOT_W-1:0] fired_slot;
    logic              was_late;
    logic [31:0]       lateness;
    logic [31:0]       ticks_to_next;
    logic              table_empty;
    logic              any_fired;
    logic              more_pending;
    logic              last;
  } sched_rec_t;

  logic [19:0] tick_rate;
  logic        armed      [NUM_SLOTS];
  logic        periodic   [NUM_SLOTS];
  logic [31:0] due_at     [NUM_SLOTS];
  logic [31:0] period_len [NUM_SLOTS];
  sched_rec_t  due_records[$];

  function automatic logic [31:0] sat_product(input logic [31:0] a, input logic [31:0] b);
    logic [63:0] p;
    p = {32'd0, a} * {32'd0, b};
    return (p > {32'd0, SAT32}) ? SAT32 : p[31:0];
  endfunction

  function automatic logic [31:0] sat_sum(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? SAT32 : s[31:0];
  endfunction

  // earliest armed slot, lowest index on ties; -1 when none is armed
  function automatic int earliest_slot();
    int best;
    best = -1;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (armed[i] && (best < 0 || due_at[i] < due_at[best])) best = i;
    end
    return best;
  endfunction

  function automatic string show(input sched_rec_t r);
    return $sformatf({"kind=%0d slot=%0d late=%0b lateness=%0d next=%0d ",
                      "empty=%0b fired=%0b more=%0b last=%0b"},
                     r.record_kind, r.fired_slot, r.was_late, r.lateness,
                     r.ticks_to_next, r.table_empty, r.any_fired, r.more_pending,
                     r.last);
  endfunction

  task automatic report(input string msg);
    if (mismatches < 10) $display("%t mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic schedule(input kind_t k, input logic [4:0] s, input logic [31:0] t,
                          input logic [15:0] wait_s, input logic [15:0] per_s,
                          input logic [31:0] when);
    logic [31:0] rate;
    int          e;
    int          n;
    sched_rec_t  r;
    rate = (tick_rate == '0) ? 32'd1 : {12'd0, tick_rate};
    if (k != KIND_CHECK) begin
      case (k)
        KIND_PERIODIC: begin
          armed[s]      = 1'b1;
          periodic[s]   = 1'b1;
          due_at[s]     = sat_sum(t, sat_product({16'd0, wait_s}, rate));
          period_len[s] = sat_product((per_s == '0) ? 32'd1 : {16'd0, per_s}, rate);
        end
        KIND_ONESHOT: begin
          armed[s]    = 1'b1;
          periodic[s] = 1'b0;
          due_at[s]   = when;
        end
        default: begin
          armed[s]    = 1'b0;
          periodic[s] = 1'b0;
        end
      endcase
      r             = '0;
      r.record_kind = 1'b1;
      r.table_empty = (earliest_slot() < 0);
      r.last        = 1'b1;
      due_records.push_back(r);
      return;
    end
    n = 0;
    forever begin
      e = earliest_slot();
      if (e < 0 || due_at[e] > t || n >= MAX_FIRES) break;
      r            = '0;
      r.fired_slot = e[SLOT_W-1:0];
      r.was_late   = (t > due_at[e]);
      r.lateness   = t - due_at[e];
      due_records.push_back(r);
      n++;
      if (periodic[e]) due_at[e] = sat_sum(due_at[e], period_len[e]);
      else armed[e] = 1'b0;
    end
    r             = '0;
    r.record_kind = 1'b1;
    r.last        = 1'b1;
    r.any_fired   = (n > 0);
    if (e < 0) r.table_empty = 1'b1;
    else if (due_at[e] > t) r.ticks_to_next = due_at[e] - t;
    else r.more_pending = 1'b1;
    due_records.push_back(r);
  endtask

  always @(posedge clk) begin : monitor
    sched_rec_t got;
    sched_rec_t want;
    if (rst) begin
      tick_rate  = TPS_RST;
      mismatches = 0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        armed[i]    = 1'b0;
        periodic[i] = 1'b0;
      end
      due_records.delete();
    end else begin
      if (out_valid && !out_stall) begin
        got = '{record_kind, fired_slot, was_late, lateness, ticks_to_next,
                table_empty, any_fired, more_pending, last};
        if (due_records.size() == 0) begin
          report({"no record expected, got ", show(got)});
        end else begin
          want = due_records.pop_front();
          if (got !== want)
            report({"expected ", show(want), " got ", show(got)});
        end
      end
      if (cfg_valid && cfg_ready) tick_rate = cfg_data;
      if (in_valid && !in_stall)
        schedule(kind_t'(kind), slot, now, initial_wait_secs, period_secs, run_when);
    end
    pending <= due_records.size();
  end

endmodule

// ===== test/timed_task_scheduler_unit_tb.sv =====
// ----------------------------------------------------------------------------
// timed_task_scheduler_unit_tb
// Drives start, cancel and check commands into the scheduler: a directed
// sequence over the corner cases, then random phases under several tick
// rates, with random gaps and output stalls and one long output hold-off.
// The checker beside the block predicts and compares every record.
// ----------------------------------------------------------------------------
module timed_task_scheduler_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tts_pkg::*;

  localparam int STALL_LIMIT  = 3000;
  localparam int HOLD_CYCLES  = 400;
  localparam int SETTLE       = 10;
  localparam int DRAIN_CYCLES = 80;
  localparam int PHASE_ITEMS  = 36;

  logic        clk;
  logic        rst;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [19:0] cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  kind;
  logic [4:0]  slot;
  logic [31:0] now;
  logic [15:0] initial_wait_secs;
  logic [15:0] period_secs;
  logic [31:0] run_when;
  logic        out_valid;
  logic        out_stall;
  logic        record_kind;
  logic [4:0]  fired_slot;
  logic        was_late;
  logic [31:0] lateness;
  logic [31:0] ticks_to_next;
  logic        table_empty;
  logic        any_fired;
  logic        more_pending;
  logic        last;
  int          mismatches;
  int          pending;

  logic        hold_req;
  bit          tx_eager;

  timed_task_scheduler_unit i_dut (.*);

  timed_task_scheduler_unit_checker i_checker (.*);

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  task automatic send_cmd(input kind_t k, input logic [4:0] s, input logic [31:0] t,
                          input logic [15:0] wait_s, input logic [15:0] per_s,
                          input logic [31:0] when);
    int gap;
    int pick;
    pick = $urandom_range(0, 99);
    gap  = 0;
    if (!tx_eager) begin
      if (pick >= 90) gap = $urandom_range(8, 60);
      else if (pick >= 55) gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid          <= 1'b1;
    kind              <= k;
    slot              <= s;
    now               <= t;
    initial_wait_secs <= wait_s;
    period_secs       <= per_s;
    run_when          <= when;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_rate(input logic [19:0] value);
    drain();
    repeat (SETTLE) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    logic [19:0] phase_rate [5];
    logic [31:0] rate;
    logic [31:0] clock_now;
    logic [31:0] t;
    logic [31:0] when;
    logic [15:0] wait_s;
    logic [15:0] per_s;
    logic [4:0]  s;
    kind_t       k;
    int          pick;

    rst               <= 1'b1;
    cfg_valid         <= 1'b0;
    cfg_data          <= '0;
    in_valid          <= 1'b0;
    kind              <= KIND_CHECK;
    slot              <= '0;
    now               <= '0;
    initial_wait_secs <= '0;
    period_secs       <= '0;
    run_when          <= '0;
    hold_req          <= 1'b0;
    tx_eager          = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed part at the reset tick rate
    send_cmd(KIND_CHECK,    5'd0,  32'd0,        16'd0,      16'd0,      32'd0);
    send_cmd(KIND_CANCEL,   5'd7,  32'd0,        16'd0,      16'd0,      32'd0);
    send_cmd(KIND_ONESHOT,  5'd0,  32'd0,        16'd0,      16'd0,      32'd0);
    send_cmd(KIND_PERIODIC, 5'd31, 32'd0,        16'd0,      16'd0,      32'd0);
    send_cmd(KIND_ONESHOT,  5'd5,  32'd0,        16'd0,      16'd0,      SAT32);
    send_cmd(KIND_CHECK,    5'd0,  32'd3000,     16'd0,      16'd0,      32'd0);
    send_cmd(KIND_CANCEL,   5'd31, 32'd0,        16'd0,      16'd0,      32'd0);
    send_cmd(KIND_CHECK,    5'd0,  32'd0,        16'd0,      16'd0,      32'd0);
    send_cmd(KIND_PERIODIC, 5'd3,  SAT32,        16'hFFFF,   16'hFFFF,   32'd0);
    send_cmd(KIND_CHECK,    5'd0,  SAT32,        16'd0,      16'd0,      32'd0);
    send_cmd(KIND_ONESHOT,  5'd3,  32'd0,        16'd0,      16'd0,      32'd100);
    send_cmd(KIND_CANCEL,   5'd5,  32'd0,        16'd0,      16'd0,      32'd0);
    send_cmd(KIND_CHECK,    5'd0,  32'd99,       16'd0,      16'd0,      32'd0);
    send_cmd(KIND_CHECK,    5'd0,  32'd100,      16'd0,      16'd0,      32'd0);
    send_cmd(KIND_PERIODIC, 5'd10, 32'd500,      16'd2,      16'd1,      32'd0);
    send_cmd(KIND_PERIODIC, 5'd10, 32'd0,        16'd0,      16'hFFFF,   32'd0);
    send_cmd(KIND_CHECK,    5'd0,  32'd1,        16'd0,      16'd0,      32'd0);
    send_cmd(KIND_CANCEL,   5'd10, 32'd0,        16'd0,      16'd0,      32'd0);

    // random phases, each under its own tick rate
    phase_rate[0] = 20'd0;
    phase_rate[1] = 20'd1;
    phase_rate[2] = 20'd1000000;
    phase_rate[3] = 20'hFFFFF;
    phase_rate[4] = 20'($urandom_range(2, 999999));
    clock_now = '0;
    for (int ph = 0; ph < 5; ph++) begin
      write_rate(phase_rate[ph]);
      rate     = (phase_rate[ph] == '0) ? 32'd1 : {12'd0, phase_rate[ph]};
      tx_eager = (ph == 1);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        pick   = $urandom_range(0, 99);
        s      = 5'($urandom_range(0, 31));
        t      = $urandom;
        wait_s = 16'($urandom);
        per_s  = 16'($urandom);
        when   = $urandom;
        if (pick < 35) begin
          k = KIND_PERIODIC;
          if ($urandom_range(0, 19) != 0) begin
            t      = clock_now;
            wait_s = 16'($urandom_range(0, 3));
            per_s  = 16'($urandom_range(0, 4));
          end
        end else if (pick < 60) begin
          k = KIND_ONESHOT;
          if ($urandom_range(0, 9) != 0) when = clock_now + $urandom_range(0, 4 * rate);
        end else if (pick < 70) begin
          k = KIND_CANCEL;
        end else begin
          k = KIND_CHECK;
          clock_now = clock_now + $urandom_range(0, 3 * rate);
          if ($urandom_range(0, 19) != 0) t = clock_now;
        end
        if (ph == 2 && i == 8) hold_req <= 1'b1;
        send_cmd(k, s, t, wait_s, per_s, when);
      end
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // output side: random stall runs, one long hold-off on request
  initial begin : receiver
    int  pick;
    bit  held;
    held = 1'b0;
    out_stall <= 1'b0;
    forever begin
      if (hold_req && !held) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end else if (pick < 90) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end else begin
        out_stall <= 1'b1;
        repeat ($urandom_range(10, 40)) @(posedge clk);
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
          (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("FAILED: results differ");
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/tts_pkg.sv
hw/rtl/tts_sat_unit.sv
hw/rtl/timed_task_scheduler_unit.sv
test/timed_task_scheduler_unit_checker.sv
test/timed_task_scheduler_unit_tb.sv
